@@ sv/kpu_pkg.sv @@
// Shared types, constants and the factorial lookup function for the permutation unranking unit.
`timescale 1ns / 1ps

package kpu_pkg;

   // Largest symbol count that the unit serves.
   localparam int MAX_SYMBOLS = 9;

   // Field widths of the request and response words.
   localparam int NDIG_W = 4;
   localparam int RANK_W = 19;
   localparam int SYM_W  = 4;
   localparam int POS_W  = 4;
   localparam int STAT_W = 2;

   // Factorials up to 12! fit in 32 bits.
   localparam int FACT_W = 32;
   // A quotient never exceeds the number of remaining symbols less one.
   localparam int QUO_W  = $clog2(MAX_SYMBOLS + 1);

   // Status codes carried in each response word.
   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   // Control from the sequencer to the divider.
   typedef struct packed {
      logic              start;
      logic [RANK_W-1:0] dividend;
      logic [NDIG_W-1:0] fact_idx;
   } div_ctrl_type;

   // Result of the divider.
   typedef struct packed {
      logic              done;
      logic [QUO_W-1:0]  quotient;
      logic [RANK_W-1:0] remainder;
   } div_stat_type;

   // Control from the sequencer to the symbol selector.
   typedef struct packed {
      logic             clear;
      logic             take;
      logic [QUO_W-1:0] index;
   } pick_ctrl_type;

   // Factorial of m for m up to 12; larger arguments give 0.
   function automatic logic [FACT_W-1:0] fact_of(input logic [NDIG_W-1:0] m);
      logic [FACT_W-1:0] f;
      case (m)
         4'd0:    f = 32'd1;
         4'd1:    f = 32'd1;
         4'd2:    f = 32'd2;
         4'd3:    f = 32'd6;
         4'd4:    f = 32'd24;
         4'd5:    f = 32'd120;
         4'd6:    f = 32'd720;
         4'd7:    f = 32'd5040;
         4'd8:    f = 32'd40320;
         4'd9:    f = 32'd362880;
         4'd10:   f = 32'd3628800;
         4'd11:   f = 32'd39916800;
         4'd12:   f = 32'd479001600;
         default: f = 32'd0;
      endcase
      return f;
   endfunction

endpackage

@@ sv/kpu_if.sv @@
// Valid/ready channel interfaces for the request and response words.
`timescale 1ns / 1ps

interface kpu_req_if
   import kpu_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [NDIG_W-1:0] n_digits;
   logic [RANK_W-1:0] rank;

   modport source (output valid, output n_digits, output rank, input ready);
   modport sink   (input valid, input n_digits, input rank, output ready);
endinterface

interface kpu_rsp_if
   import kpu_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [SYM_W-1:0]  digit;
   logic [POS_W-1:0]  position;
   logic [STAT_W-1:0] status;
   logic              last;

   modport source (output valid, output digit, output position, output status,
                   output last, input ready);
   modport sink   (input valid, input digit, input position, input status,
                   input last, output ready);
endinterface

@@ sv/kpu_div_unit.sv @@
// Iterative divider: divides the running rank by a factorial through repeated subtraction.
`timescale 1ns / 1ps

module kpu_div_unit
   import kpu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_ctrl_type ctrl,
   output div_stat_type stat
);

   logic                busy_ff, busy_in;
   logic [RANK_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic [FACT_W-1:0]   divisor_ff, divisor_in;
   logic                fits;

   // One subtract and compare per cycle; the quotient is small.
   assign fits = (FACT_W'(rem_ff) >= divisor_ff);

   always_comb begin
      busy_in    = busy_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (ctrl.start) begin
         busy_in    = 1'b1;
         rem_in     = ctrl.dividend;
         quo_in     = '0;
         divisor_in = fact_of(ctrl.fact_idx);
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - divisor_ff[RANK_W-1:0];
            quo_in = quo_ff + QUO_W'(1);
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign stat.done      = busy_ff && !fits;
   assign stat.quotient  = quo_ff;
   assign stat.remainder = rem_ff;

endmodule

@@ sv/kpu_pick_unit.sv @@
// Symbol selector: keeps the used-symbol mask and finds the n-th unused symbol.
`timescale 1ns / 1ps

module kpu_pick_unit
   import kpu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  pick_ctrl_type    ctrl,
   output logic [SYM_W-1:0] symbol
);

   logic [MAX_SYMBOLS-1:0] used_ff, used_in;
   logic [MAX_SYMBOLS-1:0] pick_onehot;
   logic [QUO_W-1:0]       seen;
   logic                   found;

   // Walk the mask from the smallest symbol and stop at the wanted unused one.
   always_comb begin
      seen        = '0;
      found       = 1'b0;
      symbol      = '0;
      pick_onehot = '0;
      for (int s = 0; s < MAX_SYMBOLS; s++) begin
         if (!used_ff[s] && !found) begin
            if (seen == ctrl.index) begin
               found          = 1'b1;
               symbol         = SYM_W'(s + 1);
               pick_onehot[s] = 1'b1;
            end
            seen = seen + QUO_W'(1);
         end
      end
   end

   always_comb begin
      used_in = used_ff;
      if (ctrl.clear) begin
         used_in = '0;
      end else if (ctrl.take) begin
         used_in = used_ff | pick_onehot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

endmodule

@@ sv/kth_permutation_unrank_unit.sv @@
// Top level of the lexicographic permutation unranking unit.
`timescale 1ns / 1ps

// The unit takes a request word with a symbol count n and a one-based rank k
// and answers with the k-th permutation of 1..n in lexicographic order, one
// response word per position, with last set on the final word. A request with
// n or k zero gives a single word with the empty status; a request with n above
// MAX_SYMBOLS or k above n factorial gives a single word with the range status.
// The unit handles one request at a time and is not ready while it works on
// one. It first checks a request, then for each position p the shared
// subtract unit finds the quotient q(p) with one subtraction per unit of it,
// and the word for p is then presented; for nine symbols the quotients sum
// to at most 36. After the last word the unit returns to idle before it can
// take the next request, so the shared subtract unit limits how often
// requests are taken.
module kth_permutation_unrank_unit
   import kpu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   kpu_req_if.sink    req_ch,
   kpu_rsp_if.source  rsp_ch
);

   state_type state_ff, state_in;

   logic [NDIG_W-1:0] n_ff, n_in;
   logic [RANK_W-1:0] r_ff, r_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SYM_W-1:0]  digit_ff, digit_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              last_ff, last_in;

   div_ctrl_type      div_ctrl;
   div_stat_type      div_stat;
   pick_ctrl_type     pick_ctrl;
   logic [SYM_W-1:0]  pick_symbol;

   logic              req_fire;
   logic              rsp_fire;
   logic              is_empty;
   logic              is_range;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   // Special cases are decided once, in the check cycle.
   assign is_empty = (n_ff == '0) || (r_ff == '0);
   assign is_range = (n_ff > NDIG_W'(MAX_SYMBOLS)) ||
                     (FACT_W'(r_ff) > fact_of(n_ff));

   kpu_div_unit u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   kpu_pick_unit u_pick (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (pick_ctrl),
      .symbol (pick_symbol)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (is_empty || is_range) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_fire) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath updates. Ready is high in idle and valid is high in
   // the result state, so the other side of each handshake alone decides here.
   always_comb begin
      req_ch.ready      = 1'b0;
      rsp_ch.valid      = 1'b0;
      div_ctrl.start    = 1'b0;
      div_ctrl.dividend = r_ff;
      div_ctrl.fact_idx = n_ff - NDIG_W'(1);
      pick_ctrl.clear   = 1'b0;
      pick_ctrl.take    = 1'b0;
      pick_ctrl.index   = div_stat.quotient;
      n_in              = n_ff;
      r_in              = r_ff;
      pos_in            = pos_ff;
      digit_in          = digit_ff;
      status_in         = status_ff;
      last_in           = last_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               n_in = req_ch.n_digits;
               r_in = req_ch.rank;
            end
         end
         ST_CHECK: begin
            pos_in          = '0;
            pick_ctrl.clear = 1'b1;
            if (is_empty) begin
               digit_in  = '0;
               status_in = STATUS_EMPTY;
               last_in   = 1'b1;
            end else if (is_range) begin
               digit_in  = '0;
               status_in = STATUS_RANGE;
               last_in   = 1'b1;
            end else begin
               // Work on the zero-based rank; first divisor is (n-1)!.
               div_ctrl.start    = 1'b1;
               div_ctrl.dividend = r_ff - RANK_W'(1);
               div_ctrl.fact_idx = n_ff - NDIG_W'(1);
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               pick_ctrl.take = 1'b1;
               digit_in       = pick_symbol;
               r_in           = div_stat.remainder;
               status_in      = STATUS_OK;
               last_in        = (NDIG_W'(pos_ff) == n_ff - NDIG_W'(1));
            end
         end
         ST_RESULT: begin
            rsp_ch.valid = 1'b1;
            if (rsp_ch.ready && !last_ff) begin
               // Next position divides by (n-2-p)!.
               pos_in            = pos_ff + POS_W'(1);
               div_ctrl.start    = 1'b1;
               div_ctrl.dividend = r_ff;
               div_ctrl.fact_idx = n_ff - NDIG_W'(pos_ff) - NDIG_W'(2);
            end
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff      <= n_in;
      r_ff      <= r_in;
      pos_ff    <= pos_in;
      digit_ff  <= digit_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_ch.digit    = digit_ff;
   assign rsp_ch.position = pos_ff;
   assign rsp_ch.status   = status_ff;
   assign rsp_ch.last     = last_ff;

endmodule

@@ test/kth_permutation_unrank_unit_tb.sv @@
// Self-checking testbench for the permutation unranking unit.
`timescale 1ns / 1ps

module kth_permutation_unrank_unit_tb;
   import kpu_pkg::*;

   // One response word as the unit presents it.
   typedef struct packed {
      logic [SYM_W-1:0]  digit;
      logic [POS_W-1:0]  position;
      logic [STAT_W-1:0] status;
      logic              last;
   } perm_word_type;

   // Number of orderings of m symbols, built up by multiplication.
   function automatic int unsigned orderings(input int m);
      int unsigned f;
      f = 1;
      for (int i = 2; i <= m; i++) f = f * i;
      return f;
   endfunction

   // Works out the response words of each accepted request and checks the
   // words that come back, oldest first.
   class unrank_scoreboard_type;
      perm_word_type awaited_words[$];
      int            errors;

      function new();
         errors = 0;
      endfunction

      function void push_word(input logic [SYM_W-1:0] digit, input int position,
                              input logic [STAT_W-1:0] status, input bit last);
         perm_word_type w;
         w.digit    = digit;
         w.position = position[POS_W-1:0];
         w.status   = status;
         w.last     = last;
         awaited_words.push_back(w);
      endfunction

      // Walks the remaining rank down through shrinking factorials and takes
      // the symbol at the quotient's index among those not yet used.
      function void note_request(input logic [NDIG_W-1:0] n_digits,
                                 input logic [RANK_W-1:0] rank);
         bit          taken[MAX_SYMBOLS];
         int unsigned rest, f, idx, seen;
         int          pick;
         bit          found;
         if (n_digits == 0 || rank == 0) begin
            push_word('0, 0, STATUS_EMPTY, 1'b1);
         end else if (n_digits > MAX_SYMBOLS) begin
            push_word('0, 0, STATUS_RANGE, 1'b1);
         end else if (rank > orderings(n_digits)) begin
            push_word('0, 0, STATUS_RANGE, 1'b1);
         end else begin
            for (int s = 0; s < MAX_SYMBOLS; s++) taken[s] = 1'b0;
            rest = rank - 1;
            for (int p = 0; p < n_digits; p++) begin
               f     = orderings(n_digits - 1 - p);
               idx   = rest / f;
               rest  = rest % f;
               seen  = 0;
               pick  = 0;
               found = 1'b0;
               for (int s = 0; s < n_digits; s++) begin
                  if (!found && !taken[s]) begin
                     if (seen == idx) begin
                        pick  = s;
                        found = 1'b1;
                     end else begin
                        seen++;
                     end
                  end
               end
               taken[pick] = 1'b1;
               push_word(SYM_W'(pick + 1), p, STATUS_OK, (p + 1 == n_digits));
            end
         end
      endfunction

      function void check_word(input perm_word_type got);
         perm_word_type want;
         if (awaited_words.size() == 0) begin
            $error("unexpected word: digit %0d position %0d status %0d last %0d",
                   got.digit, got.position, got.status, got.last);
            errors++;
         end else begin
            want = awaited_words.pop_front();
            if (got.digit !== want.digit) begin
               $error("digit: expected %0d actual %0d", want.digit, got.digit);
               errors++;
            end
            if (got.position !== want.position) begin
               $error("position: expected %0d actual %0d", want.position, got.position);
               errors++;
            end
            if (got.status !== want.status) begin
               $error("status: expected %0d actual %0d", want.status, got.status);
               errors++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0d actual %0d", want.last, got.last);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   kpu_req_if req_ch ();
   kpu_rsp_if rsp_ch ();

   kth_permutation_unrank_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   unrank_scoreboard_type word_board = new();

   // When set, neither side inserts idle cycles.
   bit steady_phase = 1'b0;
   // The request side bumps holds_asked to make the response side hold off for
   // a long stretch; the response side counts that stretch itself.
   int holds_asked = 0;
   int holds_done  = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Response-side ready: random stall bursts, plus the long hold-off on request.
   // It changes only at the falling edge, so the unit sees it settled. This
   // process alone drives ready.
   int stall_left = 0;
   int hold_left  = 0;
   always @(negedge clock) begin
      if (holds_asked != holds_done) begin
         holds_done++;
         hold_left = 250;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!steady_phase && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Every word that crosses the response channel is checked at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         word_board.check_word({rsp_ch.digit, rsp_ch.position, rsp_ch.status,
                                rsp_ch.last});
      end
   end

   // Offers one request word from a falling edge and holds it until the unit
   // takes it. Valid is left high so the caller can either follow with the
   // next word or drop valid for a gap, with one assignment per edge.
   task automatic send_request(input logic [NDIG_W-1:0] n_digits,
                               input logic [RANK_W-1:0] rank);
      req_ch.valid    <= 1'b1;
      req_ch.n_digits <= n_digits;
      req_ch.rank     <= rank;
      do @(posedge clock); while (!req_ch.ready);
      word_board.note_request(n_digits, rank);
      @(negedge clock);
   endtask

   task automatic idle_requests(input int cycles);
      req_ch.valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Holds the request side off until every awaited word has arrived.
   task automatic drain_words();
      req_ch.valid <= 1'b0;
      while (word_board.awaited_words.size() != 0) @(negedge clock);
   endtask

   // Directed requests: the empty forms, the out-of-range forms on either side
   // of n factorial, too many symbols, every permutation of three symbols, and
   // the first and last ranks at the largest supported count.
   localparam int DIRECTED = 25;
   logic [NDIG_W-1:0] dir_n [DIRECTED] = '{
      4'd0, 4'd0, 4'd5, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
      4'd3, 4'd9, 4'd9, 4'd9, 4'd9, 4'd10, 4'd15, 4'd15, 4'd4, 4'd4, 4'd8, 4'd9
   };
   logic [RANK_W-1:0] dir_k [DIRECTED] = '{
      19'd0, 19'd5, 19'd0, 19'd1, 19'd2, 19'd1, 19'd2, 19'd3, 19'd1, 19'd2, 19'd3,
      19'd4, 19'd5, 19'd6, 19'd1, 19'd362880, 19'd362881, 19'd524287, 19'd1,
      19'd524287, 19'd0, 19'd24, 19'd25, 19'd40321, 19'd181440
   };

   localparam int RANDOM_ITEMS = 400;

   initial begin
      logic [NDIG_W-1:0] n_digits;
      logic [RANK_W-1:0] rank;
      int                pick;

      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.n_digits <= '0;
      req_ch.rank     <= '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED; i++) begin
         if ($urandom_range(0, 3) == 0) idle_requests($urandom_range(1, 15));
         send_request(dir_n[i], dir_k[i]);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // The response side goes quiet for a long stretch while requests keep
         // coming, so the unit stays busy with one request and stops taking request words.
         if (i == 100) holds_asked++;
         // Here the request side waits for the unit to empty out completely.
         if (i == 200) drain_words();
         if (i == RANDOM_ITEMS - 80) steady_phase = 1'b1;

         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            // Well-formed request with a random rank.
            n_digits = NDIG_W'($urandom_range(1, MAX_SYMBOLS));
            rank     = RANK_W'($urandom_range(1, orderings(n_digits)));
         end else if (pick < 86) begin
            // First or last rank for the count.
            n_digits = NDIG_W'($urandom_range(1, MAX_SYMBOLS));
            rank     = RANK_W'($urandom_range(0, 1) ? orderings(n_digits) : 1);
         end else if (pick < 92) begin
            // Rank past the number of orderings.
            n_digits = NDIG_W'($urandom_range(1, MAX_SYMBOLS));
            rank     = RANK_W'($urandom_range(orderings(n_digits) + 1,
                                              (1 << RANK_W) - 1));
         end else if (pick < 96) begin
            // Empty request: either field zero.
            if ($urandom_range(0, 1)) begin
               n_digits = '0;
               rank     = RANK_W'($urandom_range(0, (1 << RANK_W) - 1));
            end else begin
               n_digits = NDIG_W'($urandom_range(0, (1 << NDIG_W) - 1));
               rank     = '0;
            end
         end else begin
            // More symbols than the unit supports.
            n_digits = NDIG_W'($urandom_range(MAX_SYMBOLS + 1, (1 << NDIG_W) - 1));
            rank     = RANK_W'($urandom_range(0, (1 << RANK_W) - 1));
         end

         if (!steady_phase && $urandom_range(0, 3) == 0) begin
            idle_requests($urandom_range(1, 15));
         end
         send_request(n_digits, rank);
      end

      drain_words();
      // Any stray word the unit still sends after the last one lands here.
      repeat (60) @(negedge clock);

      if (word_board.errors == 0 && word_board.awaited_words.size() == 0) begin
         $display("kth_permutation_unrank_unit_tb: clean");
      end else begin
         $display("kth_permutation_unrank_unit_tb: errors");
      end
      $finish;
   end

   // A correct run needs well under a tenth of this time.
   initial begin
      #20_000_000;
      $display("kth_permutation_unrank_unit_tb: errors");
      $finish;
   end

endmodule
